// ----- rtl/sobel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared widths, constants and types of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    // field widths
    localparam int PIX_W   = 8;   // color and intensity
    localparam int CFG_W   = 13;  // image width register
    localparam int POS_W   = 12;  // row and column fields
    localparam int GRAD_W  = 11;  // signed gradient, |g| <= 1020
    localparam int SQ_W    = 21;  // one squared gradient
    localparam int ROOT_W  = 8;   // magnitude
    localparam int RAD_W   = 16;  // radicand below saturation
    localparam int LINE_W  = 2 * PIX_W;  // upper and middle row per column
    localparam int SUM_W   = 10;  // r + g + b

    // image geometry
    localparam int MIN_WIDTH = 3;
    localparam int DEF_WIDTH = 640;
    localparam int BORDER    = 2;  // first position that completes an inner center
    localparam logic [POS_W-1:0] ROW_MAX = {POS_W{1'b1}};

    // divide by three: floor(s / 3) == (s * 683) >> 11 for s <= 765
    localparam logic [SUM_W-1:0] RECIP3    = 10'd683;
    localparam int               RECIP3_SH = 11;

    // position and flag of one center as it travels down the pipeline
    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

endpackage

// ----- rtl/sobel_line_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_line_ram
// Simple dual-port line store, one entry per column, registered read.
// ----------------------------------------------------------------------------
module sobel_line_ram import sobel_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [LINE_W-1:0] o_rdata,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [LINE_W-1:0] i_wdata
);

    logic [LINE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ----- rtl/sobel_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_window
// 3x3 intensity window and the registered Sobel gradients gx and gy.
// ----------------------------------------------------------------------------
module sobel_window import sobel_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  t_tag                     i_tag,
    input  logic [PIX_W-1:0]         i_up,
    input  logic [PIX_W-1:0]         i_mid,
    input  logic [PIX_W-1:0]         i_inten,
    output logic                     o_vld,
    output t_tag                     o_tag,
    output logic signed [GRAD_W-1:0] o_gx,
    output logic signed [GRAD_W-1:0] o_gy
);

    logic [PIX_W-1:0]         r_win [9];
    logic [PIX_W-1:0]         n_win [9];
    logic signed [GRAD_W-1:0] c [9];
    logic signed [GRAD_W-1:0] n_gx;
    logic signed [GRAD_W-1:0] n_gy;
    logic                     shift;

    assign shift = i_en && i_vld;

    // shift left one column, new column enters on the right
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[3*k]     = r_win[3*k + 1];
            n_win[3*k + 1] = r_win[3*k + 2];
        end
        n_win[2] = i_up;
        n_win[5] = i_mid;
        n_win[8] = i_inten;
    end

    // gradients over the updated window
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            c[k] = signed'({{(GRAD_W-PIX_W){1'b0}}, n_win[k]});
        end
        n_gx = (c[2] - c[0]) + ((c[5] - c[3]) <<< 1) + (c[8] - c[6]);
        n_gy = (c[6] - c[0]) + ((c[7] - c[1]) <<< 1) + (c[8] - c[2]);
    end

    // window cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (shift) begin
            r_win <= n_win;
        end
    end

    // valid of the gradient stage, only centers that are emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld && i_tag.emit;
        end
    end

    // gradient payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_gx  <= n_gx;
            o_gy  <= n_gy;
            o_tag <= i_tag;
        end
    end

endmodule

// ----- rtl/sobel_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_sqrt
// Squares, sums and takes the saturated integer square root, one bit a stage.
// ----------------------------------------------------------------------------
module sobel_sqrt import sobel_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  t_tag                     i_tag,
    input  logic signed [GRAD_W-1:0] i_gx,
    input  logic signed [GRAD_W-1:0] i_gy,
    output logic                     o_vld,
    output t_tag                     o_tag,
    output logic [ROOT_W-1:0]        o_root
);

    logic signed [2*GRAD_W-1:0] px;
    logic signed [2*GRAD_W-1:0] py;
    logic [SQ_W-1:0]            r_sqx;
    logic [SQ_W-1:0]            r_sqy;
    logic                       r_sq_vld;
    t_tag                       r_sq_tag;
    logic [SQ_W:0]              energy;

    // digit stages, entry 0 is loaded by the sum stage
    logic                       r_vld  [ROOT_W+1];
    t_tag                       r_tag  [ROOT_W+1];
    logic [RAD_W-1:0]           r_v    [ROOT_W+1];
    logic                       r_sat  [ROOT_W+1];
    logic [ROOT_W-1:0]          r_root [ROOT_W+1];
    logic [RAD_W-1:0]           r_sq   [ROOT_W+1];

    assign px     = i_gx * i_gx;
    assign py     = i_gy * i_gy;
    assign energy = {1'b0, r_sqx} + {1'b0, r_sqy};

    // square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (i_en) begin
            r_sq_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx    <= px[SQ_W-1:0];
            r_sqy    <= py[SQ_W-1:0];
            r_sq_tag <= i_tag;
        end
    end

    // sum stage, energy at or above 2^16 saturates the root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0]  <= r_sq_tag;
            r_v[0]    <= energy[RAD_W-1:0];
            r_sat[0]  <= |energy[SQ_W:RAD_W];
            r_root[0] <= '0;
            r_sq[0]   <= '0;
        end
    end

    // one root bit per stage: (root + 2^b)^2 = sq + root * 2^(b+1) + 4^b
    for (genvar k = 0; k < ROOT_W; k++) begin : g_digit
        localparam int B = ROOT_W - 1 - k;
        logic [RAD_W:0] cand;
        logic           take;

        assign cand = {1'b0, r_sq[k]} + ((RAD_W+1)'(r_root[k]) << (B + 1))
                      + ((RAD_W+1)'(1) << (2 * B));
        assign take = cand <= {1'b0, r_v[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k+1] <= r_tag[k];
                r_v[k+1]   <= r_v[k];
                r_sat[k+1] <= r_sat[k];
                if (take) begin
                    r_root[k+1] <= r_root[k] | (ROOT_W'(1) << B);
                    r_sq[k+1]   <= cand[RAD_W-1:0];
                end else begin
                    r_root[k+1] <= r_root[k];
                    r_sq[k+1]   <= r_sq[k];
                end
            end
        end
    end

    // last stage is the output register
    assign o_vld  = r_vld[ROOT_W];
    assign o_tag  = r_tag[ROOT_W];
    assign o_root = r_sat[ROOT_W] ? {ROOT_W{1'b1}} : r_root[ROOT_W];

endmodule

// ----- rtl/sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 Sobel edge magnitude over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the result side is ready. The rate is set by
// the line store, one simple dual-port RAM of MAX_WIDTH entries that holds the
// two rows above: it is read when a pixel is accepted and written back as that
// pixel leaves stage one, and a read that hits the column being written (a
// frame start right after column zero) takes the written data by forwarding.
// The root runs in eight pipelined one-bit stages. Only interior centers come
// out, one beat each, when the pixel below and to the right arrives; border
// pixels are left to downstream. tuser marks the first pixel of a frame and
// clears row and column. The line store has no clearing pass and comes out of
// reset undefined.
module sobel_edge_magnitude import sobel_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // image width register
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    // pixel input
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [23:0]      i_s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic [0:0]       i_s_axis_tuser,   // frame_start[0]
    // edge output
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata    // center_col[11:0], center_row[23:12],
                                               // magnitude[31:24]
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int RST_WIDTH = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;

    logic [WW-1:0]            r_width;
    logic [WW-1:0]            n_width;
    logic [CW-1:0]            r_col;
    logic [POS_W-1:0]         r_row;
    logic                     advance;
    logic                     s_acc;
    logic                     frame_start;
    logic [CW-1:0]            col_eff;
    logic [POS_W-1:0]         row_eff;
    logic [WW-1:0]            col_inc;
    logic [SUM_W-1:0]         pix_sum;
    logic [2*SUM_W-1:0]       pix_prod;
    logic [PIX_W-1:0]         inten;

    logic                     r1_vld;
    logic                     r1_emit;
    logic [CW-1:0]            r1_col;
    logic [POS_W-1:0]         r1_row;
    logic [PIX_W-1:0]         r1_inten;
    t_tag                     s1_tag;

    logic [LINE_W-1:0]        ram_rdata;
    logic [LINE_W-1:0]        line_q;
    logic [LINE_W-1:0]        ram_wdata;
    logic                     ram_we;
    logic                     r_fwd;
    logic [LINE_W-1:0]        r_fwd_data;

    logic                     win_vld;
    t_tag                     win_tag;
    logic signed [GRAD_W-1:0] win_gx;
    logic signed [GRAD_W-1:0] win_gy;
    t_tag                     out_tag;
    logic [ROOT_W-1:0]        out_root;

    // whole pipeline moves while the output register is free or taken
    assign advance         = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = advance;
    assign s_acc           = i_s_axis_tvalid && advance;

    // width register, clamped on write
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data < CFG_W'(MIN_WIDTH)) begin
            n_width = WW'(MIN_WIDTH);
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = WW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WW'(RST_WIDTH);
        end else if (i_cfg_valid) begin
            r_width <= n_width;
        end
    end

    // position of the incoming pixel
    assign frame_start = i_s_axis_tuser[0];
    assign col_eff     = frame_start ? '0 : r_col;
    assign row_eff     = frame_start ? '0 : r_row;
    assign col_inc     = WW'(col_eff) + WW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_acc) begin
            if (col_inc >= r_width) begin
                r_col <= '0;
                r_row <= (row_eff == ROW_MAX) ? row_eff : row_eff + POS_W'(1);
            end else begin
                r_col <= col_inc[CW-1:0];
                r_row <= row_eff;
            end
        end
    end

    // intensity (r + g + b) / 3 by reciprocal
    assign pix_sum  = SUM_W'(i_s_axis_tdata[7:0]) + SUM_W'(i_s_axis_tdata[15:8])
                      + SUM_W'(i_s_axis_tdata[23:16]);
    assign pix_prod = pix_sum * RECIP3;
    assign inten    = pix_prod[RECIP3_SH +: PIX_W];

    // stage one: pixel waits for its line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (advance) begin
            r1_vld <= s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r1_emit  <= (row_eff >= POS_W'(BORDER)) && (col_eff >= CW'(BORDER));
            r1_col   <= col_eff;
            r1_row   <= row_eff;
            r1_inten <= inten;
        end
    end

    // line store: read on accept, write back the shifted column as stage one advances
    assign ram_we    = r1_vld && advance;
    assign line_q    = r_fwd ? r_fwd_data : ram_rdata;
    assign ram_wdata = {line_q[PIX_W-1:0], r1_inten};

    sobel_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_re    (s_acc),
        .i_raddr (col_eff),
        .o_rdata (ram_rdata),
        .i_we    (ram_we),
        .i_waddr (r1_col),
        .i_wdata (ram_wdata)
    );

    // forward a write to the column read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (advance) begin
            r_fwd <= s_acc && ram_we && (col_eff == r1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fwd_data <= ram_wdata;
        end
    end

    // center sits one row up and one column left
    assign s1_tag.emit = r1_emit;
    assign s1_tag.row  = r1_row - POS_W'(1);
    assign s1_tag.col  = POS_W'(r1_col - CW'(1));

    sobel_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_vld   (r1_vld),
        .i_tag   (s1_tag),
        .i_up    (line_q[LINE_W-1:PIX_W]),
        .i_mid   (line_q[PIX_W-1:0]),
        .i_inten (r1_inten),
        .o_vld   (win_vld),
        .o_tag   (win_tag),
        .o_gx    (win_gx),
        .o_gy    (win_gy)
    );

    sobel_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_vld   (win_vld),
        .i_tag   (win_tag),
        .i_gx    (win_gx),
        .i_gy    (win_gy),
        .o_vld   (o_m_axis_tvalid),
        .o_tag   (out_tag),
        .o_root  (out_root)
    );

    // output beat
    assign o_m_axis_tdata = {out_root, out_tag.row, out_tag.col};

    // forwarded data only ever belongs to a pixel in stage one
    a_fwd_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r1_vld)
        else $error("forwarding flag without a pixel in stage one");

    // an emitted center never lies on the top border or at the row limit ROW_MAX
    a_row_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[23:12] != '0)
                            && (o_m_axis_tdata[23:12] != ROW_MAX))
        else $error("emitted center row outside the interior");

    // within a frame the column either steps by one or wraps to zero
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !frame_start |=> (r_col == $past(r_col) + CW'(1)) || (r_col == '0))
        else $error("column position did not step or wrap");

endmodule
